>>> sv/hng_pkg.sv
`default_nettype none
package hng_pkg;

   localparam int unsigned HEIGHT_W = 8;
   localparam int unsigned IDX_W    = 10;
   localparam int unsigned CFG_W    = 16;
   localparam int unsigned Q14_ONE  = 16384;

   // Magnitude widths: 16x8 products, sum of three squares, its root.
   localparam int unsigned MAG_W  = 24;
   localparam int unsigned SUM_W  = 50;
   localparam int unsigned ROOT_W = 25;
   localparam int unsigned QUO_W  = 15;

   localparam logic [0:0] CSR_HEIGHT_SCALE  = 1'b0;
   localparam logic [0:0] CSR_SPACING_TWICE = 1'b1;

   localparam logic [CFG_W-1:0] HEIGHT_SCALE_RST  = 16'd64;
   localparam logic [CFG_W-1:0] SPACING_TWICE_RST = 16'd2064;

   typedef struct packed {
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic              last;
      logic              x_neg;
      logic              z_neg;
      logic [MAG_W-1:0]  x_mag;
      logic [MAG_W-1:0]  z_mag;
      logic [CFG_W-1:0]  y_mag;
   } vec_type;

   typedef struct packed {
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
      logic               last;
      logic signed [15:0] nx;
      logic [14:0]        ny;
      logic signed [15:0] nz;
   } nrm_type;

endpackage
`default_nettype wire

>>> sv/hng_norm.sv
`default_nettype none
// Normalizer: squares, one sum, a bit-serial square root, then three
// restoring divisions of magnitude*2^14 by the root, one quotient bit a cycle.
module hng_norm (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  hng_pkg::vec_type     vec,
   output logic                 done,
   output hng_pkg::nrm_type     nrm
);
   import hng_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQ, ST_SUM, ST_ROOT, ST_DIV, ST_DONE
   } state_type;

   localparam int unsigned DIV_W = MAG_W + 15;

   state_type         state_ff;
   vec_type           vec_ff;
   logic [47:0]       sqx_ff, sqz_ff;
   logic [31:0]       sqy_ff;
   logic [SUM_W-1:0]  rem_ff;
   logic [SUM_W-1:0]  res_ff;
   logic [SUM_W-1:0]  bit_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [1:0]        comp_ff;
   logic [5:0]        step_ff;
   logic [DIV_W:0]    drem_ff;
   logic [DIV_W-1:0]  dnum_ff;
   logic [QUO_W:0]    quo_ff;
   logic [QUO_W-1:0]  qx_ff, qy_ff, qz_ff;
   logic              zero_ff;

   logic [SUM_W-1:0]  trial;
   logic [DIV_W-1:0]  num_sel;
   logic [DIV_W:0]    drem_sh;
   logic [DIV_W:0]    div_sub;
   logic [QUO_W-1:0]  quo_sat;

   assign trial   = res_ff + bit_ff;
   assign drem_sh = {drem_ff[DIV_W-1:0], dnum_ff[DIV_W-1]};
   assign div_sub = drem_sh - {{(DIV_W+1-ROOT_W){1'b0}}, root_ff};
   assign quo_sat = (quo_ff > (QUO_W+1)'(Q14_ONE)) ? QUO_W'(Q14_ONE) : quo_ff[QUO_W-1:0];

   always_comb begin
      case (comp_ff)
         2'd0:    num_sel = DIV_W'(vec_ff.x_mag) << 14;
         2'd1:    num_sel = DIV_W'(vec_ff.y_mag) << 14;
         default: num_sel = DIV_W'(vec_ff.z_mag) << 14;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: if (start) begin
               vec_ff   <= vec;
               state_ff <= ST_SQ;
            end
            ST_SQ: begin
               sqx_ff   <= vec_ff.x_mag * vec_ff.x_mag;
               sqz_ff   <= vec_ff.z_mag * vec_ff.z_mag;
               sqy_ff   <= vec_ff.y_mag * vec_ff.y_mag;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               rem_ff   <= SUM_W'(sqx_ff) + SUM_W'(sqz_ff) + SUM_W'(sqy_ff);
               res_ff   <= '0;
               bit_ff   <= SUM_W'(1) << (SUM_W - 2);
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (bit_ff == '0) begin
                  root_ff  <= res_ff[ROOT_W-1:0];
                  zero_ff  <= (res_ff == '0);
                  comp_ff  <= 2'd0;
                  step_ff  <= '0;
                  state_ff <= ST_DIV;
               end else begin
                  if (rem_ff >= trial) begin
                     rem_ff <= rem_ff - trial;
                     res_ff <= (res_ff >> 1) + bit_ff;
                  end else begin
                     res_ff <= res_ff >> 1;
                  end
                  bit_ff <= bit_ff >> 2;
               end
            end
            ST_DIV: begin
               if (step_ff == 6'd0) begin
                  // Add half the root to the dividend for rounding.
                  drem_ff <= '0;
                  dnum_ff <= num_sel + DIV_W'(root_ff >> 1);
                  quo_ff  <= '0;
                  step_ff <= 6'd1;
               end else if (step_ff <= 6'(DIV_W)) begin
                  dnum_ff <= dnum_ff << 1;
                  if (!div_sub[DIV_W]) begin
                     drem_ff <= div_sub;
                     quo_ff  <= {quo_ff[QUO_W-1:0], 1'b1} | ((quo_ff[QUO_W]) ? (QUO_W+1)'(1) << QUO_W : '0);
                  end else begin
                     drem_ff <= drem_sh;
                     quo_ff  <= {quo_ff[QUO_W-1:0], 1'b0} | ((quo_ff[QUO_W]) ? (QUO_W+1)'(1) << QUO_W : '0);
                  end
                  step_ff <= step_ff + 6'd1;
               end else begin
                  case (comp_ff)
                     2'd0:    qx_ff <= quo_sat;
                     2'd1:    qy_ff <= quo_sat;
                     default: qz_ff <= quo_sat;
                  endcase
                  step_ff <= '0;
                  if (comp_ff == 2'd2) state_ff <= ST_DONE;
                  else comp_ff <= comp_ff + 2'd1;
               end
            end
            ST_DONE: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Sticky top bit keeps saturation once the quotient overflows 15 bits.
   always_comb begin
      nrm.row  = vec_ff.row;
      nrm.col  = vec_ff.col;
      nrm.last = vec_ff.last;
      if (zero_ff) begin
         nrm.nx = '0;
         nrm.ny = 15'(Q14_ONE);
         nrm.nz = '0;
      end else begin
         nrm.nx = vec_ff.x_neg ? -$signed({1'b0, qx_ff}) : $signed({1'b0, qx_ff});
         nrm.ny = qy_ff;
         nrm.nz = vec_ff.z_neg ? -$signed({1'b0, qz_ff}) : $signed({1'b0, qz_ff});
      end
   end

   assign done = (state_ff == ST_DONE);

   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("done held");
   a_ny_range: assert property (@(posedge clock) disable iff (reset)
      done |-> nrm.ny <= 15'(Q14_ONE)) else $error("ny out of range");
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (root_ff >= ROOT_W'(vec_ff.y_mag))) else $error("root small");

endmodule
`default_nettype wire

>>> sv/heightmap_normal_generator.sv
`default_nettype none
// Heightmap normal generator, 3x3 window over two line memories.
// Path: an accepted interior sample goes through the read/update state, then the norm
//   unit's squares, sum, square root and three quotient divisions, to rsp_tvalid.
// Flow: one sample at a time; edge samples take a memory read and an update,
//   interior samples also the normalization plus any output stall.
// Reset: synchronous, active high; clears counters, window, registers to defaults;
//   line memories are not cleared.
module heightmap_normal_generator #(
   parameter int unsigned GRID_SIZE = 128
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // height[7:0]
   input  wire         req_tuser,   // frame_start
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,   // row[9:0] col[19:10] nx[35:20] ny[50:36] nz[66:51] 0
   output logic        rsp_tlast,   // last
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [0:0]  csr_index,
   input  wire  [15:0] csr_data
);
   import hng_pkg::*;

   localparam int unsigned ADDR_W = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;

   typedef enum logic [1:0] {ST_IN, ST_RD, ST_NORM, ST_OUT} state_type;

   state_type            state_ff;
   logic [HEIGHT_W-1:0]  mem_a [GRID_SIZE];
   logic [HEIGHT_W-1:0]  mem_b [GRID_SIZE];
   logic [HEIGHT_W-1:0]  rd_a_ff, rd_b_ff;
   logic [HEIGHT_W-1:0]  win_ff [3][3];
   logic [HEIGHT_W-1:0]  h_ff;
   logic [IDX_W-1:0]     row_ff, col_ff, r_ff, c_ff;
   logic [CFG_W-1:0]     scale_ff, spacing_ff;
   logic                 start_ff;
   vec_type              vec;
   vec_type              vec_ff_hold;
   nrm_type              nrm;
   nrm_type              out_ff;
   logic                 done;
   logic [IDX_W-1:0]     r_in, c_in;
   logic [HEIGHT_W-1:0]  dx, dz;

   assign req_tready = (state_ff == ST_IN);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == ST_OUT);

   always_comb begin
      r_in = req_tuser ? '0 : row_ff;
      c_in = (req_tuser || (IDX_W+1)'(col_ff) >= (IDX_W+1)'(GRID_SIZE)) ? '0 : col_ff;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         rd_a_ff <= mem_a[c_in[ADDR_W-1:0]];
         rd_b_ff <= mem_b[c_in[ADDR_W-1:0]];
      end
      if (state_ff == ST_RD) begin
         mem_a[c_ff[ADDR_W-1:0]] <= h_ff;
         mem_b[c_ff[ADDR_W-1:0]] <= rd_a_ff;
      end
   end

   // Window columns: [k][0] oldest; after shift hl=[1][0], hr=[1][2], hu=[0][1], hd=[2][1].
   always_comb begin
      logic [HEIGHT_W-1:0] l, r, u, d;
      l = win_ff[1][1]; r = rd_a_ff; u = win_ff[0][2]; d = win_ff[2][2];
      dx = (l >= r) ? l - r : r - l;
      dz = (u >= d) ? u - d : d - u;
      vec.row   = r_ff - IDX_W'(1);
      vec.col   = c_ff - IDX_W'(1);
      vec.last  = (r_ff == IDX_W'(GRID_SIZE - 1)) && (c_ff == IDX_W'(GRID_SIZE - 1));
      vec.x_neg = (l < r) && (scale_ff != '0);
      vec.z_neg = (u < d) && (scale_ff != '0);
      vec.x_mag = scale_ff * dx;
      vec.z_mag = scale_ff * dz;
      vec.y_mag = spacing_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IN;
         row_ff     <= '0;
         col_ff     <= '0;
         scale_ff   <= HEIGHT_SCALE_RST;
         spacing_ff <= SPACING_TWICE_RST;
         start_ff   <= 1'b0;
         for (int k = 0; k < 3; k++) for (int j = 0; j < 3; j++) win_ff[k][j] <= '0;
      end else begin
         start_ff <= 1'b0;
         if (csr_valid) begin
            case (csr_index)
               CSR_HEIGHT_SCALE:  scale_ff   <= csr_data;
               CSR_SPACING_TWICE: spacing_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            ST_IN: if (req_tvalid) begin
               h_ff     <= req_tdata;
               r_ff     <= r_in;
               c_ff     <= c_in;
               state_ff <= ST_RD;
            end
            ST_RD: begin
               for (int k = 0; k < 3; k++) begin
                  win_ff[k][0] <= win_ff[k][1];
                  win_ff[k][1] <= win_ff[k][2];
               end
               win_ff[0][2] <= rd_b_ff;
               win_ff[1][2] <= rd_a_ff;
               win_ff[2][2] <= h_ff;
               if (c_ff >= IDX_W'(GRID_SIZE - 1)) begin
                  col_ff <= '0;
                  row_ff <= (r_ff >= IDX_W'(GRID_SIZE - 1)) ? '0 : r_ff + IDX_W'(1);
               end else begin
                  col_ff <= c_ff + IDX_W'(1);
                  row_ff <= r_ff;
               end
               if (r_ff >= IDX_W'(2) && c_ff >= IDX_W'(2)) begin
                  start_ff <= 1'b1;
                  state_ff <= ST_NORM;
               end else begin
                  state_ff <= ST_IN;
               end
            end
            ST_NORM: if (done) begin
               out_ff   <= nrm;
               state_ff <= ST_OUT;
            end
            ST_OUT: if (rsp_tready) state_ff <= ST_IN;
            default: state_ff <= ST_IN;
         endcase
      end
   end

   hng_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .vec   (vec_ff_hold),
      .done  (done),
      .nrm   (nrm)
   );

   // Capture the vector while the window shifts; norm unit latches it on start.
   always_ff @(posedge clock) begin
      if (state_ff == ST_RD) vec_ff_hold <= vec;
   end

   assign rsp_tdata = {5'd0, out_ff.nz, out_ff.ny, out_ff.nx, out_ff.col, out_ff.row};
   assign rsp_tlast = out_ff.last;

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> !rsp_tvalid) else $error("repeat beat");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accept during output");
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_ff.col >= IDX_W'(1) && out_ff.row >= IDX_W'(1))) else $error("edge");

endmodule
`default_nettype wire
